>>> hdl/usgs_pkg.sv
package usgs_pkg;

    localparam int unsigned DIR_BITS  = 16;
    localparam int unsigned ROOT_BITS = 31;
    localparam int unsigned NS_BITS   = 15;
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned REM_S_W   = 34;
    localparam int unsigned RAD_W     = 62;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MAGZERO = 2'd1;
    localparam logic [1:0] ST_LENZERO = 2'd2;

    localparam logic REG_STEP = 1'b0;
    localparam logic REG_MAG  = 1'b1;

    typedef struct packed {
        logic [2:0][15:0] spin;
        logic [2:0]       gneg;
        logic [2:0]       ovf;
        logic             last;
        logic             mzero;
    } t_side_a;

    typedef struct packed {
        logic [2:0][15:0] dir;
        logic [2:0][30:0] wabs;
        logic [2:0]       wneg;
        logic             last;
        logic             mzero;
    } t_side_c;

    typedef struct packed {
        logic [2:0][15:0] dir;
        logic [2:0]       wneg;
        logic             last;
        logic             mzero;
        logic             lzero;
        logic [31:0]      len;
    } t_side_d;

endpackage

>>> hdl/usgs_div_cell.sv
module usgs_div_cell #(
    parameter int unsigned W_D = 32,
    parameter int unsigned W_Q = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W_D-1:0] i_rem,
    input  logic [W_Q-1:0] i_num,
    input  logic [W_Q-1:0] i_quo,
    input  logic [W_D-1:0] i_div,
    output logic [W_D-1:0] o_rem,
    output logic [W_Q-1:0] o_num,
    output logic [W_Q-1:0] o_quo
);

    logic [W_D:0] t;
    logic [W_D:0] d;
    logic         ge;

    assign t  = {i_rem, i_num[W_Q-1]};
    assign d  = {1'b0, i_div};
    assign ge = (t >= d);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= ge ? W_D'(t - d) : W_D'(t);
            o_quo <= {i_quo[W_Q-2:0], ge};
            o_num <= {i_num[W_Q-2:0], 1'b0};
        end
    end

endmodule

>>> hdl/usgs_sqrt_cell.sv
module usgs_sqrt_cell (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [usgs_pkg::REM_S_W-1:0]         i_rem,
    input  logic [usgs_pkg::RAD_W-1:0]           i_rad,
    input  logic [usgs_pkg::ROOT_BITS-1:0]       i_root,
    output logic [usgs_pkg::REM_S_W-1:0]         o_rem,
    output logic [usgs_pkg::RAD_W-1:0]           o_rad,
    output logic [usgs_pkg::ROOT_BITS-1:0]       o_root
);

    logic [usgs_pkg::REM_S_W+1:0] t;
    logic [usgs_pkg::REM_S_W+1:0] trial;
    logic                         ge;

    assign t     = {i_rem, i_rad[usgs_pkg::RAD_W-1 -: 2]};
    assign trial = {3'b000, i_root, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= ge ? usgs_pkg::REM_S_W'(t - trial) : usgs_pkg::REM_S_W'(t);
            o_root <= {i_root[usgs_pkg::ROOT_BITS-2:0], ge};
            o_rad  <= {i_rad[usgs_pkg::RAD_W-3:0], 2'b00};
        end
    end

endmodule

>>> hdl/unit_spin_gradient_step_top.sv
// Spin gradient step: one atom's spin and gradient per request, one result per request.
// Input channel: i_valid / o_ready with spin and gradient fields and last_atom.
// Output channel: o_valid / i_ready with the renormalized spin, the step direction,
// batch_end and status (0 ok, 1 zero gradient magnitude, 2 spin length zero).
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 step_size, 1 grad_magnitude); write only while no request is in flight.
// Throughput: one request per cycle while the receiver takes results. Datapath:
// a chain of cells: 16 gradient divider cells (one quotient bit each),
// four arithmetic stages, 31 square root cells (one root bit each) and 15
// renormalizing divider cells.
// The whole chain advances together; when the receiver stalls with a result
// waiting, the chain holds and o_ready falls; bubbles inside the chain are held too.
// Synchronous active-low reset empties the chain and sets step_size to 0
// and grad_magnitude to 1.0.
module unit_spin_gradient_step_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_spin_x,
    input  logic signed [15:0] i_spin_y,
    input  logic signed [15:0] i_spin_z,
    input  logic signed [31:0] i_grad_x,
    input  logic signed [31:0] i_grad_y,
    input  logic signed [31:0] i_grad_z,
    input  logic               i_last_atom,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_new_spin_x,
    output logic signed [15:0] o_new_spin_y,
    output logic signed [15:0] o_new_spin_z,
    output logic signed [15:0] o_step_dir_x,
    output logic signed [15:0] o_step_dir_y,
    output logic signed [15:0] o_step_dir_z,
    output logic               o_batch_end,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int unsigned NDQ = usgs_pkg::DIR_BITS;
    localparam int unsigned NSQ = usgs_pkg::ROOT_BITS;
    localparam int unsigned NNQ = usgs_pkg::NS_BITS;

    logic        en;
    logic [15:0] r_step;
    logic [31:0] r_mag;

    assign en      = ~o_valid | i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_mag  <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                usgs_pkg::REG_STEP: r_step <= i_cfg_data[15:0];
                usgs_pkg::REG_MAG:  r_mag  <= i_cfg_data;
                default:            r_step <= r_step;
            endcase
        end
    end

    // gradient division front end
    logic [2:0][31:0] gin;
    logic [2:0][31:0] gabs;
    logic [2:0]       govf;

    assign gin = {i_grad_z, i_grad_y, i_grad_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gabs[k] = gin[k][31] ? 32'(~gin[k] + 32'd1) : gin[k];
            govf[k] = ({2'b00, gabs[k]} >= {r_mag, 2'b00});
        end
    end

    logic                 r_va [0:NDQ];
    usgs_pkg::t_side_a    r_sa [0:NDQ];
    logic [31:0]          rem_a [0:NDQ][0:2];
    logic [NDQ-1:0]       num_a [0:NDQ][0:2];
    logic [NDQ-1:0]       quo_a [0:NDQ][0:2];
    logic [2:0][31:0]     r_rem0;
    logic [2:0][NDQ-1:0]  r_num0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem0[k] <= {2'b00, gabs[k][31:2]};
                r_num0[k] <= {gabs[k][1:0], 14'b0};
            end
            r_sa[0].spin  <= {i_spin_z, i_spin_y, i_spin_x};
            r_sa[0].gneg  <= {i_grad_z[31], i_grad_y[31], i_grad_x[31]};
            r_sa[0].ovf   <= govf;
            r_sa[0].last  <= i_last_atom;
            r_sa[0].mzero <= (r_mag == 32'd0);
            for (int j = 1; j <= NDQ; j++) begin
                r_sa[j] <= r_sa[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NDQ; j++) begin
                r_va[j] <= 1'b0;
            end
        end else if (en) begin
            r_va[0] <= i_valid;
            for (int j = 1; j <= NDQ; j++) begin
                r_va[j] <= r_va[j-1];
            end
        end
    end

    genvar gj, gk;
    generate
        for (gk = 0; gk < 3; gk++) begin : g_a0
            assign rem_a[0][gk] = r_rem0[gk];
            assign num_a[0][gk] = r_num0[gk];
            assign quo_a[0][gk] = '0;
        end
        for (gj = 0; gj < NDQ; gj++) begin : g_da
            for (gk = 0; gk < 3; gk++) begin : g_ax
                usgs_div_cell #(.W_D(usgs_pkg::DIV_W), .W_Q(NDQ)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_rem (rem_a[gj][gk]),
                    .i_num (num_a[gj][gk]),
                    .i_quo (quo_a[gj][gk]),
                    .i_div (r_mag),
                    .o_rem (rem_a[gj+1][gk]),
                    .o_num (num_a[gj+1][gk]),
                    .o_quo (quo_a[gj+1][gk])
                );
            end
        end
    endgenerate

    // saturate step direction
    logic                r_vb;
    logic [2:0][15:0]    r_dirb;
    logic [2:0][15:0]    r_spinb;
    logic                r_lastb;
    logic                r_mzb;
    logic [2:0][15:0]    dir_n;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_sa[NDQ].mzero) begin
                dir_n[k] = '0;
            end else if (r_sa[NDQ].ovf[k]) begin
                dir_n[k] = r_sa[NDQ].gneg[k] ? 16'h8000 : 16'h7FFF;
            end else if (r_sa[NDQ].gneg[k]) begin
                dir_n[k] = (quo_a[NDQ][k][15] && (quo_a[NDQ][k][14:0] != 15'd0))
                         ? 16'h8000 : 16'(-quo_a[NDQ][k]);
            end else begin
                dir_n[k] = quo_a[NDQ][k][15] ? 16'h7FFF : quo_a[NDQ][k];
            end
        end
    end

    // move spin
    logic                     r_vc;
    logic [2:0][31:0]         r_wc;
    logic [2:0][15:0]         r_dirc;
    logic                     r_lastc;
    logic                     r_mzc;
    logic signed [32:0]       prod [0:2];
    logic signed [32:0]       tq   [0:2];
    logic [2:0][31:0]         w_n;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = $signed({1'b0, r_step}) * $signed(r_dirb[k]);
            tq[k]   = prod[k][32] ? ((prod[k] + 33'sd3) >>> 2) : (prod[k] >>> 2);
            w_n[k]  = {{2{r_spinb[k][15]}}, r_spinb[k], 14'b0} - tq[k][31:0];
        end
    end

    // square
    logic                     r_vd;
    usgs_pkg::t_side_c        r_scd;
    logic [2:0][61:0]         r_sq;
    logic [2:0][30:0]         wabs_n;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wabs_n[k] = r_wc[k][31] ? 31'(~r_wc[k] + 32'd1) : r_wc[k][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dirb  <= dir_n;
            r_spinb <= r_sa[NDQ].spin;
            r_lastb <= r_sa[NDQ].last;
            r_mzb   <= r_sa[NDQ].mzero;
            r_wc    <= w_n;
            r_dirc  <= r_dirb;
            r_lastc <= r_lastb;
            r_mzc   <= r_mzb;
            for (int k = 0; k < 3; k++) begin
                r_scd.wabs[k] <= wabs_n[k];
                r_scd.wneg[k] <= r_wc[k][31];
                r_sq[k]       <= wabs_n[k] * wabs_n[k];
            end
            r_scd.dir   <= r_dirc;
            r_scd.last  <= r_lastc;
            r_scd.mzero <= r_mzc;
        end
    end

    // square root chain
    logic                          r_vs [0:NSQ];
    usgs_pkg::t_side_c             r_sc [0:NSQ];
    logic [usgs_pkg::RAD_W-1:0]    r_sum;
    logic [usgs_pkg::REM_S_W-1:0]  rem_s  [0:NSQ];
    logic [usgs_pkg::RAD_W-1:0]    rad_s  [0:NSQ];
    logic [NSQ-1:0]                root_s [0:NSQ];

    assign rem_s[0]  = '0;
    assign rad_s[0]  = r_sum;
    assign root_s[0] = '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sc[0] <= r_scd;
            for (int j = 1; j <= NSQ; j++) begin
                r_sc[j] <= r_sc[j-1];
            end
        end
    end

    generate
        for (gj = 0; gj < NSQ; gj++) begin : g_sq
            usgs_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_rem  (rem_s[gj]),
                .i_rad  (rad_s[gj]),
                .i_root (root_s[gj]),
                .o_rem  (rem_s[gj+1]),
                .o_rad  (rad_s[gj+1]),
                .o_root (root_s[gj+1])
            );
        end
    endgenerate

    // renormalizing division chain
    logic                 r_vn [0:NNQ];
    usgs_pkg::t_side_d    r_sd [0:NNQ];
    logic [2:0][31:0]     r_rem2;
    logic [2:0][NNQ-1:0]  r_num2;
    logic [31:0]          rem_n [0:NNQ][0:2];
    logic [NNQ-1:0]       num_n [0:NNQ][0:2];
    logic [NNQ-1:0]       quo_n [0:NNQ][0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem2[k] <= {2'b00, r_sc[NSQ].wabs[k][30:1]};
                r_num2[k] <= {r_sc[NSQ].wabs[k][0], 14'b0};
            end
            r_sd[0].dir   <= r_sc[NSQ].dir;
            r_sd[0].wneg  <= r_sc[NSQ].wneg;
            r_sd[0].last  <= r_sc[NSQ].last;
            r_sd[0].mzero <= r_sc[NSQ].mzero;
            r_sd[0].lzero <= (root_s[NSQ] == '0);
            r_sd[0].len   <= {1'b0, root_s[NSQ]};
            for (int j = 1; j <= NNQ; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
        end
    end

    generate
        for (gk = 0; gk < 3; gk++) begin : g_n0
            assign rem_n[0][gk] = r_rem2[gk];
            assign num_n[0][gk] = r_num2[gk];
            assign quo_n[0][gk] = '0;
        end
        for (gj = 0; gj < NNQ; gj++) begin : g_dn
            for (gk = 0; gk < 3; gk++) begin : g_ax
                usgs_div_cell #(.W_D(usgs_pkg::DIV_W), .W_Q(NNQ)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_rem (rem_n[gj][gk]),
                    .i_num (num_n[gj][gk]),
                    .i_quo (quo_n[gj][gk]),
                    .i_div (r_sd[gj].len),
                    .o_rem (rem_n[gj+1][gk]),
                    .o_num (num_n[gj+1][gk]),
                    .o_quo (quo_n[gj+1][gk])
                );
            end
        end
    endgenerate

    // valid chain past the gradient divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
            for (int j = 0; j <= NSQ; j++) begin
                r_vs[j] <= 1'b0;
            end
            for (int j = 0; j <= NNQ; j++) begin
                r_vn[j] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (en) begin
            r_vb    <= r_va[NDQ];
            r_vc    <= r_vb;
            r_vd    <= r_vc;
            r_vs[0] <= r_vd;
            for (int j = 1; j <= NSQ; j++) begin
                r_vs[j] <= r_vs[j-1];
            end
            r_vn[0] <= r_vs[NSQ];
            for (int j = 1; j <= NNQ; j++) begin
                r_vn[j] <= r_vn[j-1];
            end
            o_valid <= r_vn[NNQ];
        end
    end

    // output register
    logic [2:0][15:0] ns_n;
    logic [1:0]       st_n;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_sd[NNQ].lzero) begin
                ns_n[k] = '0;
            end else if (r_sd[NNQ].wneg[k]) begin
                ns_n[k] = 16'(-{1'b0, quo_n[NNQ][k]});
            end else begin
                ns_n[k] = {1'b0, quo_n[NNQ][k]};
            end
        end
        if (r_sd[NNQ].lzero) begin
            st_n = usgs_pkg::ST_LENZERO;
        end else if (r_sd[NNQ].mzero) begin
            st_n = usgs_pkg::ST_MAGZERO;
        end else begin
            st_n = usgs_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_new_spin_x <= ns_n[0];
            o_new_spin_y <= ns_n[1];
            o_new_spin_z <= ns_n[2];
            o_step_dir_x <= r_sd[NNQ].dir[0];
            o_step_dir_y <= r_sd[NNQ].dir[1];
            o_step_dir_z <= r_sd[NNQ].dir[2];
            o_batch_end  <= r_sd[NNQ].last;
            o_status     <= st_n;
        end
    end

endmodule
